FILE: design/pptxb_pkg.sv
// Package for the ping-pong transmit buffer controller.
// Holds sizes, input/result codes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package pptxb_pkg;

   localparam int BUF_DEPTH = 64;
   localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
   localparam int MEM_DEPTH = 2 * (1 << IDX_W);

   localparam logic [1:0] KIND_APPEND = 2'd0;
   localparam logic [1:0] KIND_EOM    = 2'd1;
   localparam logic [1:0] KIND_TXDONE = 2'd2;

   localparam logic RK_BYTE   = 1'b0;
   localparam logic RK_REFUSE = 1'b1;

   typedef struct packed {
      logic append;       // store a byte in the filling buffer
      logic use_pend;     // take the byte from the held character
      logic latch_char;   // hold the incoming character
      logic start;        // put the filling buffer on the line
      logic mark_filled;  // mark the filling buffer filled
      logic clear_sent;   // empty the buffer on the line
      logic idle_line;    // line goes idle on the sent buffer
      logic rd_issue;     // read the next byte of the run
      logic hold_refuse;  // hold the id of the full buffer
      logic refuse_load;  // place a refusal in the result register
   } ctl_cmd_type;

   typedef struct packed {
      logic fb_full;
      logic fb_empty;
      logic fb_filled;
      logic busy;
      logic rd_can_issue;
      logic rd_last;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: design/ping_pong_tx_buffer_controller.sv
// Ping-pong transmit buffer controller, top level.
// Instantiates pptxb_ctrl and pptxb_dp; depends on pptxb_pkg.
//
// Use: items enter on req_ (req_kind: append character, end of message,
// transmit done) and results leave on rsp_: each result is one transmitted
// byte or one refusal, and a started buffer gives one result per byte.
// Both channels are valid/stall.
// An append into a buffer with room gives no result.
// Starting a buffer of N bytes holds req_stall high while the bytes are read
// out of the single-port byte store, one per cycle unless rsp_stall holds the
// run; each byte passes through the read stage into the result register on
// rsp_, and the last byte carries rsp_last. A start caused by an append into a
// full buffer is followed by the deferred append of the held character. A
// refusal passes through a refuse state and waits for earlier bytes to leave.
// When rsp_stall is high the result register and one read stage hold; the run
// pauses but appends keep being accepted while the line is not being read.
// Reset empties both buffers and leaves the line idle on ping; the byte store
// is not cleared, only written entries are ever sent.
`timescale 1ns / 1ps

module ping_pong_tx_buffer_controller
   import pptxb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_char_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_buffer_id,
   output logic       rsp_last
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   pptxb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .stat      (stat),
      .cmd       (cmd)
   );

   pptxb_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_char_value  (req_char_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_buffer_id   (rsp_buffer_id),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: design/pptxb_dp.sv
// Datapath of the ping-pong transmit buffer controller: byte store, fill counts,
// filled flags, line phase, run read pipeline and result register.
// Depends on pptxb_pkg.
`timescale 1ns / 1ps

module pptxb_dp
   import pptxb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type cmd,
   output dp_stat_type stat,
   input  logic [7:0]  req_char_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_buffer_id,
   output logic        rsp_last
);

   logic [7:0]       mem [MEM_DEPTH];

   logic [CNT_W-1:0] cnt_ff [2];
   logic [CNT_W-1:0] cnt_in [2];
   logic [1:0]       filled_ff, filled_in;
   logic             nb_ff, nb_in;
   logic             busy_ff, busy_in;

   logic             run_buf_ff, run_buf_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [7:0]       pend_ff;
   logic             refuse_id_ff;

   logic             b_vld_ff, b_vld_in;
   logic [7:0]       rd_data_ff;
   logic             b_id_ff;
   logic             b_last_ff;

   logic             c_vld_ff, c_vld_in;
   logic             c_kind_ff, c_kind_in;
   logic [7:0]       c_byte_ff, c_byte_in;
   logic             c_id_ff, c_id_in;
   logic             c_last_ff, c_last_in;

   logic             fb;
   logic [CNT_W-1:0] cnt_fb;
   logic [CNT_W-1:0] idx_next;
   logic             rd_last;
   logic             c_take;
   logic             b_move;
   logic [7:0]       wr_data;

   assign fb       = ~nb_ff;
   assign cnt_fb   = cnt_ff[fb];
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);
   assign rd_last  = (idx_next == len_ff);
   assign c_take   = ~c_vld_ff | ~rsp_stall;
   assign b_move   = b_vld_ff & c_take;
   assign wr_data  = cmd.use_pend ? pend_ff : req_char_value;

   always_comb begin
      stat.fb_full      = (cnt_fb == CNT_W'(BUF_DEPTH));
      stat.fb_empty     = (cnt_fb == '0);
      stat.fb_filled    = filled_ff[fb];
      stat.busy         = busy_ff;
      stat.rd_can_issue = ~b_vld_ff | b_move;
      stat.rd_last      = rd_last;
      stat.out_free     = ~b_vld_ff & c_take;
   end

   // state next values
   always_comb begin
      cnt_in     = cnt_ff;
      filled_in  = filled_ff;
      nb_in      = nb_ff;
      busy_in    = busy_ff;
      run_buf_in = run_buf_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      if (cmd.append) begin
         cnt_in[fb] = cnt_fb + CNT_W'(1);
      end
      if (cmd.mark_filled) begin
         filled_in[fb] = 1'b1;
      end
      if (cmd.clear_sent) begin
         cnt_in[nb_ff]    = '0;
         filled_in[nb_ff] = 1'b0;
      end
      if (cmd.idle_line) begin
         busy_in = 1'b0;
      end
      if (cmd.start) begin
         filled_in[fb] = 1'b1;
         nb_in         = fb;
         busy_in       = 1'b1;
         run_buf_in    = fb;
         len_in        = cnt_fb;
         idx_in        = '0;
      end
      if (cmd.rd_issue) begin
         idx_in = IDX_W'(idx_next);
      end
   end

   always_comb begin
      b_vld_in = b_vld_ff;
      if (cmd.rd_issue) begin
         b_vld_in = 1'b1;
      end else if (b_move) begin
         b_vld_in = 1'b0;
      end
   end

   always_comb begin
      c_vld_in  = c_vld_ff;
      c_kind_in = c_kind_ff;
      c_byte_in = c_byte_ff;
      c_id_in   = c_id_ff;
      c_last_in = c_last_ff;
      if (b_move) begin
         c_vld_in  = 1'b1;
         c_kind_in = RK_BYTE;
         c_byte_in = rd_data_ff;
         c_id_in   = b_id_ff;
         c_last_in = b_last_ff;
      end else if (cmd.refuse_load) begin
         c_vld_in  = 1'b1;
         c_kind_in = RK_REFUSE;
         c_byte_in = '0;
         c_id_in   = refuse_id_ff;
         c_last_in = 1'b1;
      end else if (c_vld_ff && !rsp_stall) begin
         c_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
         filled_ff <= '0;
         nb_ff     <= 1'b0;
         busy_ff   <= 1'b0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
      end else begin
         cnt_ff[0] <= cnt_in[0];
         cnt_ff[1] <= cnt_in[1];
         filled_ff <= filled_in;
         nb_ff     <= nb_in;
         busy_ff   <= busy_in;
         b_vld_ff  <= b_vld_in;
         c_vld_ff  <= c_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      run_buf_ff <= run_buf_in;
      len_ff     <= len_in;
      idx_ff     <= idx_in;
      c_kind_ff  <= c_kind_in;
      c_byte_ff  <= c_byte_in;
      c_id_ff    <= c_id_in;
      c_last_ff  <= c_last_in;
      if (cmd.latch_char) begin
         pend_ff <= req_char_value;
      end
      if (cmd.hold_refuse) begin
         refuse_id_ff <= fb;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[{fb, cnt_fb[IDX_W-1:0]}] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[{run_buf_ff, idx_ff}];
         b_id_ff    <= run_buf_ff;
         b_last_ff  <= rd_last;
      end
   end

   assign rsp_valid       = c_vld_ff;
   assign rsp_result_kind = c_kind_ff;
   assign rsp_byte_out    = c_byte_ff;
   assign rsp_buffer_id   = c_id_ff;
   assign rsp_last        = c_last_ff;

endmodule

FILE: design/pptxb_ctrl.sv
// Controller of the ping-pong transmit buffer controller: decodes items and
// sequences transmission runs, the deferred append and refusals.
// Depends on pptxb_pkg.
`timescale 1ns / 1ps

module pptxb_ctrl
   import pptxb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_RUN    = 2'd1;
   localparam logic [1:0] S_APPEND = 2'd2;
   localparam logic [1:0] S_REFUSE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       after_ff, after_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      after_in = after_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_APPEND: begin
                     if (!stat.fb_full) begin
                        cmd.append = 1'b1;
                     end else if (stat.busy) begin
                        cmd.hold_refuse = 1'b1;
                        state_in        = S_REFUSE;
                     end else begin
                        cmd.start      = 1'b1;
                        cmd.latch_char = 1'b1;
                        after_in       = 1'b1;
                        state_in       = S_RUN;
                     end
                  end
                  KIND_EOM: begin
                     if (!stat.fb_empty) begin
                        if (!stat.busy) begin
                           cmd.start = 1'b1;
                           after_in  = 1'b0;
                           state_in  = S_RUN;
                        end else begin
                           cmd.mark_filled = 1'b1;
                        end
                     end
                  end
                  KIND_TXDONE: begin
                     if (stat.busy) begin
                        cmd.clear_sent = 1'b1;
                        if (stat.fb_filled && !stat.fb_empty) begin
                           cmd.start = 1'b1;
                           after_in  = 1'b0;
                           state_in  = S_RUN;
                        end else begin
                           cmd.idle_line = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RUN: begin
            if (stat.rd_can_issue) begin
               cmd.rd_issue = 1'b1;
               if (stat.rd_last) begin
                  state_in = after_ff ? S_APPEND : S_IDLE;
               end
            end
         end
         S_APPEND: begin
            if (!stat.fb_full) begin
               cmd.append   = 1'b1;
               cmd.use_pend = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.hold_refuse = 1'b1;
               state_in        = S_REFUSE;
            end
         end
         S_REFUSE: begin
            if (stat.out_free) begin
               cmd.refuse_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         after_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
      end
   end

endmodule

FILE: design/pptxb_chk.sv
// Port checker for the ping-pong transmit buffer controller, bound to the top.
// Depends on pptxb_pkg.
`timescale 1ns / 1ps

module pptxb_chk
   import pptxb_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_result_kind,
   input logic [7:0] rsp_byte_out,
   input logic       rsp_buffer_id,
   input logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_byte_out) && $stable(rsp_buffer_id) && $stable(rsp_last))
      else $error("stalled result changed");

   a_refuse_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RK_REFUSE |-> rsp_last && rsp_byte_out == 8'd0)
      else $error("refusal without last mark or with nonzero byte");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall right after reset");

   a_run_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_result_kind == RK_BYTE && !rsp_last
         |=> rsp_valid && rsp_result_kind == RK_BYTE && $stable(rsp_buffer_id))
      else $error("gap or buffer change inside a transmission run");

endmodule

bind ping_pong_tx_buffer_controller pptxb_chk u_pptxb_chk (.*);

FILE: bench/testbench.sv
// Self-checking bench for ping_pong_tx_buffer_controller: directed and random items,
// random idling on both channels, results checked in order against a scoreboard.
// Depends on pptxb_pkg and the design files.
`timescale 1ns / 1ps

module testbench;
   import pptxb_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int TOTAL_ITEMS  = 220;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 20;

   typedef enum logic [1:0] {BUF_EMPTY, BUF_FILLING, BUF_FILLED} buf_state_type;
   typedef enum logic [1:0] {
      PING_IDLE, PING_SENDING, PONG_IDLE, PONG_SENDING
   } line_phase_type;

   typedef struct packed {
      logic       rk;
      logic [7:0] data;
      logic       id;
      logic       last;
   } tx_result_type;

   // Tracks both buffers and the line, and holds the bytes the line should see.
   class tx_scoreboard_type;
      logic [7:0]     store [2][BUF_DEPTH];
      int unsigned    fill [2];
      buf_state_type  status [2];
      line_phase_type phase;
      tx_result_type  expected_q [$];
      int             errors;
      int             bytes_sent;
      int             refusals;
      int             items;

      function new();
         fill[0] = 0;
         fill[1] = 0;
         status[0] = BUF_EMPTY;
         status[1] = BUF_EMPTY;
         phase = PING_IDLE;
         errors = 0;
         bytes_sent = 0;
         refusals = 0;
         items = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void push_refusal(int b);
         tx_result_type r;
         r.rk = RK_REFUSE;
         r.data = 8'h00;
         r.id = b[0];
         r.last = 1'b1;
         expected_q.push_back(r);
      endfunction

      function void start_run(int b);
         tx_result_type r;
         for (int i = 0; i < int'(fill[b]); i++) begin
            r.rk = RK_BYTE;
            r.data = store[b][i];
            r.id = b[0];
            r.last = (i + 1 == int'(fill[b]));
            expected_q.push_back(r);
         end
         status[b] = BUF_FILLED;
         phase = (b != 0) ? PONG_SENDING : PING_SENDING;
      endfunction

      function bit append(int b, logic [7:0] ch);
         if (fill[b] >= BUF_DEPTH) return 1'b0;
         store[b][fill[b]] = ch;
         fill[b]++;
         if (status[b] != BUF_FILLED) status[b] = BUF_FILLING;
         return 1'b1;
      endfunction

      function void note_item(logic [1:0] kind, logic [7:0] ch);
         int cb;
         int fb;
         cb = int'(phase[1]);
         fb = cb ^ 1;
         items++;
         case (kind)
            KIND_APPEND: begin
               if (!append(fb, ch)) begin
                  if (phase[0]) begin
                     push_refusal(fb);
                  end else begin
                     start_run(fb);
                     if (!append(int'(phase[1]) ^ 1, ch)) push_refusal(int'(phase[1]) ^ 1);
                  end
               end
            end
            KIND_EOM: begin
               if (fill[fb] != 0) begin
                  if (!phase[0]) start_run(fb);
                  else status[fb] = BUF_FILLED;
               end
            end
            KIND_TXDONE: begin
               if (phase[0]) begin
                  fill[cb] = 0;
                  status[cb] = BUF_EMPTY;
                  if (status[fb] == BUF_FILLED && fill[fb] != 0) start_run(fb);
                  else phase = (cb != 0) ? PONG_IDLE : PING_IDLE;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic rk, logic [7:0] data, logic id, logic last);
         tx_result_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result: kind %0d byte %02h buffer %0d last %0d",
                   rk, data, id, last);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (rk !== e.rk) begin
            $error("result_kind: expected %0d, got %0d", e.rk, rk);
            errors++;
         end
         if (data !== e.data) begin
            $error("byte_out: expected %02h, got %02h", e.data, data);
            errors++;
         end
         if (id !== e.id) begin
            $error("buffer_id: expected %0d, got %0d", e.id, id);
            errors++;
         end
         if (last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last);
            errors++;
         end
         if (e.rk == RK_REFUSE) refusals++;
         else bytes_sent++;
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind = KIND_APPEND;
   logic [7:0] req_char_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_result_kind;
   logic [7:0] rsp_byte_out;
   logic       rsp_buffer_id;
   logic       rsp_last;

   tx_scoreboard_type sb;
   bit                idle_on = 1'b1;
   int                cycles = 0;

   ping_pong_tx_buffer_controller u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_char_value  (req_char_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_buffer_id   (rsp_buffer_id),
      .rsp_last        (rsp_last)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         sb.check_result(rsp_result_kind, rsp_byte_out, rsp_buffer_id, rsp_last);
   end

   // Result side back-pressure.
   initial begin
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   task automatic send(logic [1:0] kind, logic [7:0] ch);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_char_value <= ch;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_item(kind, ch);
   endtask

   task automatic append_chars(int n);
      for (int i = 0; i < n; i++) send(KIND_APPEND, 8'($urandom));
   endtask

   initial begin
      int len;
      int pick;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty and ignored cases while idle
      send(KIND_EOM, 8'h00);
      send(KIND_TXDONE, 8'hFF);
      send(KIND_UNUSED, 8'hA5);
      // short message sent at once, then a second one queued behind it
      send(KIND_APPEND, 8'h00);
      send(KIND_APPEND, 8'hFF);
      send(KIND_EOM, 8'h5A);
      send(KIND_APPEND, 8'h5A);
      send(KIND_EOM, 8'h00);
      send(KIND_APPEND, 8'hC3);
      send(KIND_EOM, 8'h3C);
      send(KIND_TXDONE, 8'h00);
      send(KIND_EOM, 8'h81);
      send(KIND_TXDONE, 8'h7E);
      send(KIND_TXDONE, 8'h00);
      send(KIND_UNUSED, 8'h5A);
      // full buffer while idle, then full buffer while sending
      append_chars(BUF_DEPTH);
      send(KIND_APPEND, 8'hFF);
      append_chars(BUF_DEPTH - 1);
      send(KIND_APPEND, 8'h01);
      send(KIND_EOM, 8'h00);
      send(KIND_APPEND, 8'h80);
      send(KIND_TXDONE, 8'h00);
      send(KIND_TXDONE, 8'hFF);

      while (sb.items < TOTAL_ITEMS) begin
         if (sb.items > (TOTAL_ITEMS * 3) / 4) idle_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send(2'($urandom_range(0, 3)), 8'($urandom));
         end else if (pick < 25) begin
            send(KIND_TXDONE, 8'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 12) len = 0;
            else if (pick < 82) len = $urandom_range(1, 12);
            else len = $urandom_range(BUF_DEPTH - 4, BUF_DEPTH + 4);
            append_chars(len);
            send(KIND_EOM, 8'($urandom));
            if ($urandom_range(0, 2) == 0) send(KIND_TXDONE, 8'($urandom));
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items accepted: %0d bytes sent, %0d refusals checked",
               sb.items, sb.bytes_sent, sb.refusals);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
